// ===== sv/scope_trigger_capture_macros.svh =====
// Assertion macros for the scope trigger capture block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef SCOPE_TRIGGER_CAPTURE_MACROS_SVH
`define SCOPE_TRIGGER_CAPTURE_MACROS_SVH

// Checked outside reset only.
`define STC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define STC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/stc_pkg.sv =====
// Package for the scope trigger capture block: sizes, op and register codes,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package stc_pkg;

  // Ring depth must be a power of two (start position wraps by truncation).
  localparam int RING_FRAMES  = 4096;
  localparam int SEARCH_PAIRS = 1024;
  localparam int WINDOW_MAX   = 2048;

  localparam int RING_AW  = $clog2(RING_FRAMES);
  localparam int SNAP_AW  = $clog2(WINDOW_MAX);
  localparam int PAIR_W   = (SEARCH_PAIRS > 1) ? $clog2(SEARCH_PAIRS) : 1;
  localparam int CNT_W    = 12;
  localparam int IDX_W    = 11;
  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 2 * SAMPLE_W;
  localparam int SUM_W    = ((RING_AW > CNT_W) ? RING_AW : CNT_W) + 1;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_REFRESH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] REG_LEVEL   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FALLING = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MODE    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CHAN_ON = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CHAN    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_WINDOW  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_CYCLE   = 3'd6;

  typedef struct packed {
    logic wr_frame;       // store input frame at write pointer
    logic start_refresh;  // load start position, clear counters
    logic clr_flag;
    logic ring_rd;        // read ring at current position
    logic pos_dec;
    logic latch_later;    // hold later sample of the pair
    logic set_flag;
    logic pair_inc;
    logic copy_issue;     // copy step: advance position and count, queue snapshot write
    logic commit;         // snapshot count takes the window
    logic snap_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic pair_last;
    logic copy_last;
    logic win_zero;
    logic mode;
    logic chan_on;
    logic flag;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/stc_ctrl.sv =====
// Controller state machine of the scope trigger capture block.
// Depends on stc_pkg; drives commands into stc_datapath.
`default_nettype none

module stc_ctrl import stc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SRCH_A = 3'd1;
  localparam logic [2:0] ST_SRCH_B = 3'd2;
  localparam logic [2:0] ST_SRCH_C = 3'd3;
  localparam logic [2:0] ST_COPY   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_WRITE: begin
              cmd.wr_frame = 1'b1;
            end
            OP_REFRESH: begin
              cmd.start_refresh = 1'b1;
              if (sts.mode && sts.chan_on) begin
                cmd.clr_flag = 1'b1;
                state_nxt    = ST_SRCH_A;
              end else if (!sts.mode || sts.flag) begin
                if (sts.win_zero) begin
                  cmd.commit = 1'b1;
                  state_nxt  = ST_DONE;
                end else begin
                  state_nxt = ST_COPY;
                end
              end else begin
                state_nxt = ST_DONE;
              end
            end
            OP_READ: begin
              cmd.snap_rd = 1'b1;
              state_nxt   = ST_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRCH_A: begin
        cmd.ring_rd = 1'b1;
        cmd.pos_dec = 1'b1;
        state_nxt   = ST_SRCH_B;
      end
      ST_SRCH_B: begin
        cmd.ring_rd     = 1'b1;
        cmd.latch_later = 1'b1;
        state_nxt       = ST_SRCH_C;
      end
      ST_SRCH_C: begin
        if (sts.hit) begin
          cmd.set_flag = 1'b1;
          if (sts.win_zero) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_COPY;
          end
        end else if (sts.pair_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.pos_dec  = 1'b1;
          cmd.pair_inc = 1'b1;
          state_nxt    = ST_SRCH_A;
        end
      end
      ST_COPY: begin
        cmd.ring_rd    = 1'b1;
        cmd.copy_issue = 1'b1;
        if (sts.copy_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stc_datapath.sv =====
// Datapath of the scope trigger capture block: settings, ring and snapshot
// memories, search position and counters, edge compare, output register.
// Depends on stc_pkg; commanded by stc_ctrl.
`default_nettype none

module stc_datapath import stc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic                       cfg_we,
  input  logic [CFG_IW-1:0]          cfg_index,
  input  logic [CFG_DW-1:0]          cfg_data,
  input  logic signed [SAMPLE_W-1:0] in_sample_a,
  input  logic signed [SAMPLE_W-1:0] in_sample_b,
  input  logic [IDX_W-1:0]           in_read_index,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_was_triggered,
  output logic                       out_captured,
  output logic [CNT_W-1:0]           out_valid_frames,
  output logic signed [SAMPLE_W-1:0] out_a,
  output logic signed [SAMPLE_W-1:0] out_b
);

  // settings
  logic signed [SAMPLE_W-1:0] level_r;
  logic                       falling_r;
  logic                       mode_r;
  logic                       chan_on_r;
  logic                       chan_r;
  logic [CNT_W-1:0]           window_r;
  logic [CNT_W-1:0]           cycle_r;

  // block state
  logic [RING_AW-1:0] wp_r;
  logic [RING_AW-1:0] pos_r;
  logic [RING_AW-1:0] pos_nxt;
  logic [PAIR_W-1:0]  pair_r;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               wr_v_r;
  logic [SNAP_AW-1:0] wr_idx_r;
  logic [CNT_W-1:0]   count_r;
  logic               flag_r;
  logic               res_captured_r;
  logic               res_read_r;
  logic               rd_ok_r;
  logic               out_valid_r;

  logic signed [SAMPLE_W-1:0] later_r;
  logic [FRAME_W-1:0]         ring_q_r;
  logic [FRAME_W-1:0]         snap_q_r;

  logic [FRAME_W-1:0] ring_mem [RING_FRAMES];
  logic [FRAME_W-1:0] snap_mem [WINDOW_MAX];

  logic [CNT_W-1:0]           win;
  logic [SUM_W-1:0]           start_sum;
  logic [RING_AW-1:0]         start_pos;
  logic signed [SAMPLE_W-1:0] early_s;
  logic                       hit;

  function automatic logic signed [SAMPLE_W-1:0] chan_sel(input logic [FRAME_W-1:0] frame,
                                                          input logic sel);
    return sel ? frame[FRAME_W-1:SAMPLE_W] : frame[SAMPLE_W-1:0];
  endfunction

  assign win = (window_r > CNT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : window_r;

  // start = write pointer - cycle - window, wrapped on the ring
  assign start_sum = SUM_W'(wp_r) - SUM_W'(cycle_r) - SUM_W'(win);
  assign start_pos = start_sum[RING_AW-1:0];

  assign early_s = chan_sel(ring_q_r, chan_r);
  assign hit     = falling_r ? (later_r < level_r && early_s > level_r)
                             : (later_r > level_r && early_s < level_r);

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.start_refresh) begin
      pos_nxt = start_pos;
    end else if (cmd.pos_dec) begin
      pos_nxt = (pos_r == '0) ? RING_AW'(RING_FRAMES - 1) : pos_r - 1'b1;
    end else if (cmd.copy_issue) begin
      pos_nxt = (pos_r == RING_AW'(RING_FRAMES - 1)) ? '0 : pos_r + 1'b1;
    end
  end

  assign sts.hit       = hit;
  assign sts.pair_last = (pair_r == PAIR_W'(SEARCH_PAIRS - 1));
  assign sts.copy_last = (rd_cnt_r == win - 1'b1);
  assign sts.win_zero  = (win == '0);
  assign sts.mode      = mode_r;
  assign sts.chan_on   = chan_on_r;
  assign sts.flag      = flag_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      falling_r <= 1'b0;
      mode_r    <= 1'b0;
      chan_on_r <= 1'b1;
      chan_r    <= 1'b0;
      window_r  <= CNT_W'(1024);
      cycle_r   <= CNT_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL:   level_r   <= cfg_data[SAMPLE_W-1:0];
        REG_FALLING: falling_r <= cfg_data[0];
        REG_MODE:    mode_r    <= cfg_data[0];
        REG_CHAN_ON: chan_on_r <= cfg_data[0];
        REG_CHAN:    chan_r    <= cfg_data[0];
        REG_WINDOW:  window_r  <= cfg_data[CNT_W-1:0];
        REG_CYCLE:   cycle_r   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r           <= '0;
      count_r        <= '0;
      flag_r         <= 1'b0;
      wr_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      wr_v_r <= cmd.copy_issue;
      if (cmd.wr_frame) begin
        wp_r <= (wp_r == RING_AW'(RING_FRAMES - 1)) ? '0 : wp_r + 1'b1;
      end
      if (cmd.set_flag) begin
        flag_r <= 1'b1;
      end else if (cmd.clr_flag) begin
        flag_r <= 1'b0;
      end
      if (cmd.commit) begin
        count_r <= win;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // search and copy bookkeeping
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    wr_idx_r <= rd_cnt_r[SNAP_AW-1:0];
    if (cmd.start_refresh) begin
      pair_r   <= '0;
      rd_cnt_r <= '0;
    end else begin
      if (cmd.pair_inc) begin
        pair_r <= pair_r + 1'b1;
      end
      if (cmd.copy_issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
    if (cmd.latch_later) begin
      later_r <= chan_sel(ring_q_r, chan_r);
    end
    if (cmd.commit) begin
      res_captured_r <= 1'b1;
    end else if (cmd.start_refresh) begin
      res_captured_r <= 1'b0;
    end
    if (cmd.start_refresh) begin
      res_read_r <= 1'b0;
    end else if (cmd.snap_rd) begin
      res_read_r <= 1'b1;
      rd_ok_r    <= (CNT_W'(in_read_index) < count_r);
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_frame) begin
      ring_mem[wp_r] <= {in_sample_b, in_sample_a};
    end
    if (cmd.ring_rd) begin
      ring_q_r <= ring_mem[pos_r];
    end
  end

  // snapshot memory: each copy write follows its ring read in the next cycle
  always_ff @(posedge clk) begin
    if (wr_v_r) begin
      snap_mem[wr_idx_r] <= ring_q_r;
    end
    if (cmd.snap_rd) begin
      snap_q_r <= snap_mem[in_read_index[SNAP_AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_was_triggered <= flag_r;
      out_captured      <= res_captured_r && !res_read_r;
      out_valid_frames  <= count_r;
      if (res_read_r && rd_ok_r) begin
        out_a <= snap_q_r[SAMPLE_W-1:0];
        out_b <= snap_q_r[FRAME_W-1:SAMPLE_W];
      end else begin
        out_a <= '0;
        out_b <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/scope_trigger_capture.sv =====
// Two-channel scope capture with edge trigger: a ring of stereo frames, a
// trigger search that walks back from a start point, and a snapshot window.
// Op codes: write a frame (no word out), refresh (one word out: trigger
// flag, captured, snapshot frame count), read one snapshot frame (one word
// out, with out_a/out_b zero past the frame count). Writes can follow
// each other every cycle. A read loads its snapshot frame into the
// output register once that is free. A refresh starts one cycle-length
// plus one window behind the write pointer; in triggered mode with the
// trigger channel on it tests one frame pair at a time in states SRCH_A,
// SRCH_B and SRCH_C, up to SEARCH_PAIRS pairs, each step stepping back
// two frames; the copy then moves one frame per cycle. Both loops are
// paced by the single read port of the ring memory. The input side
// accepts one word at a time; a finished result sits in the output
// register while writes (and the next command) are taken. Settings are
// written through the cfg port (always ready); the user must write them
// only while the block is idle, the block itself does not enforce it.
// Memories are not cleared at reset: read only what has been written.
`default_nettype none

module scope_trigger_capture import stc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  // command words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_op,
  input  logic signed [SAMPLE_W-1:0] in_sample_a,
  input  logic signed [SAMPLE_W-1:0] in_sample_b,
  input  logic [IDX_W-1:0]           in_read_index,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_was_triggered,
  output logic                       out_captured,
  output logic [CNT_W-1:0]           out_valid_frames,
  output logic signed [SAMPLE_W-1:0] out_a,
  output logic signed [SAMPLE_W-1:0] out_b,
  // settings
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IW-1:0]          cfg_index,
  input  logic [CFG_DW-1:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // settings registers take every write at once
  assign cfg_ready = 1'b1;

  stc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .in_read_index     (in_read_index),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_was_triggered (out_was_triggered),
    .out_captured      (out_captured),
    .out_valid_frames  (out_valid_frames),
    .out_a             (out_a),
    .out_b             (out_b)
  );

endmodule

`default_nettype wire

// ===== sv/stc_checker.sv =====
// Port-level checker for scope_trigger_capture, attached by bind.
// Depends on stc_pkg and scope_trigger_capture_macros.svh.
`default_nettype none
`include "scope_trigger_capture_macros.svh"

module stc_checker import stc_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [OP_W-1:0]            in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_captured,
  input logic [CNT_W-1:0]           out_valid_frames,
  input logic signed [SAMPLE_W-1:0] out_a,
  input logic signed [SAMPLE_W-1:0] out_b
);

  `STC_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result word during reset")
  `STC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b) && $stable(out_valid_frames), "stalled result word changed")
  `STC_ASSERT(a_write_stream, in_valid && in_ready && in_op == OP_WRITE |=> in_ready, "frame write blocked the next word")
  `STC_ASSERT(a_refresh_no_data, out_valid && out_captured |-> out_a == '0 && out_b == '0, "refresh word carries sample data")
  `STC_ASSERT(a_empty_snapshot, out_valid && out_valid_frames == '0 |-> out_a == '0 && out_b == '0, "data read from empty snapshot")

endmodule

bind scope_trigger_capture stc_checker u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_captured     (out_captured),
  .out_valid_frames (out_valid_frames),
  .out_a            (out_a),
  .out_b            (out_b)
);

`default_nettype wire
